// ===== rtl/core/mse_pkg.sv =====
// Package for the MIPS-I subset execute block: opcodes, functs, FSM states, muldiv request.
// No dependencies.
`default_nettype none
package mse_pkg;
  localparam logic [5:0] OP_SPECIAL = 6'd0, OP_REGIMM = 6'd1, OP_J = 6'd2, OP_JAL = 6'd3,
    OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLEZ = 6'd6, OP_BGTZ = 6'd7, OP_ADDI = 6'd8,
    OP_ADDIU = 6'd9, OP_SLTI = 6'd10, OP_SLTIU = 6'd11, OP_ANDI = 6'd12, OP_ORI = 6'd13,
    OP_XORI = 6'd14, OP_LUI = 6'd15, OP_LB = 6'd32, OP_LH = 6'd33, OP_LW = 6'd35,
    OP_LBU = 6'd36, OP_LHU = 6'd37, OP_SB = 6'd40, OP_SH = 6'd41, OP_SW = 6'd43,
    OP_IN = 6'd50, OP_OUT = 6'd51;
  localparam logic [5:0] FN_SLL = 6'd0, FN_SRL = 6'd2, FN_SRA = 6'd3, FN_SLLV = 6'd4,
    FN_SRLV = 6'd6, FN_SRAV = 6'd7, FN_JR = 6'd8, FN_JALR = 6'd9, FN_MFHI = 6'd16,
    FN_MFLO = 6'd18, FN_MULT = 6'd24, FN_MULTU = 6'd25, FN_DIV = 6'd26, FN_DIVU = 6'd27,
    FN_ADD = 6'd32, FN_ADDU = 6'd33, FN_SUB = 6'd34, FN_SUBU = 6'd35, FN_AND = 6'd36,
    FN_OR = 6'd37, FN_XOR = 6'd38, FN_NOR = 6'd39, FN_SLT = 6'd42, FN_SLTU = 6'd43;
  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_WB, ST_OUT
  } state_t;
  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/mse_muldiv.sv =====
// Iterative multiply/divide unit: one bit per cycle, 32 steps.
// Depends on mse_pkg.
`default_nettype none
module mse_muldiv
  import mse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire md_req_t     req,
  input  wire logic        is_div,
  output logic             busy,
  output logic [31:0]      hi,
  output logic [31:0]      lo
);
  logic [5:0]  count;
  logic        div_mode, neg_q, neg_r;
  logic [31:0] mcand, acc_lo, rem;
  logic [31:0] acc_hi;
  logic [32:0] msum;
  logic [32:0] trial;
  logic [31:0] qn, rn;

  assign trial = {rem[31:0], acc_lo[31]} - {1'b0, mcand};
  assign msum = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, mcand} : 33'd0);
  assign qn = neg_q ? -acc_lo : acc_lo;
  assign rn = neg_r ? -rem : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.start) begin
      count <= 6'd32;
    end else if (count != 6'd0) begin
      count <= count - 6'd1;
    end
  end

  // Multiply: shift-add on magnitudes. Divide: restoring on magnitudes.
  always_ff @(posedge clk) begin
    if (req.start) begin
      div_mode <= is_div;
      neg_q <= req.is_signed & (req.a[31] ^ req.b[31]);
      neg_r <= req.is_signed & req.a[31];
      mcand <= (req.is_signed && req.b[31]) ? -req.b : req.b;
      acc_lo <= (req.is_signed && req.a[31]) ? -req.a : req.a;
      acc_hi <= '0;
      rem <= '0;
    end else if (count != 6'd0) begin
      if (div_mode) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          acc_lo <= {acc_lo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], acc_lo[31]};
          acc_lo <= {acc_lo[30:0], 1'b0};
        end
      end else begin
        acc_hi <= msum[32:1];
        acc_lo <= {msum[0], acc_lo[31:1]};
      end
    end
  end

  // Multiply product is {acc_hi, acc_lo} after the last step.
  logic [63:0] prod, prod_s;
  assign prod = {acc_hi, acc_lo};
  assign prod_s = neg_q ? -prod : prod;
  assign busy = (count != 6'd0);
  assign hi = div_mode ? rn : prod_s[63:32];
  assign lo = div_mode ? qn : prod_s[31:0];
endmodule
`default_nettype wire

// ===== rtl/core/mips32_subset_execute.sv =====
// MIPS-I subset execute block: register file and data memory in synchronous RAMs.
// Read, execute and output states lie between acceptance and result valid; one
// instruction is in flight at a time, the next accepted once the result is taken.
// MULT/MULTU and DIV/DIVU by nonzero also pass MUL, DIV, WB for the bit-serial unit.
// Reset: a clearing pass over all DATA_WORDS words zeroes data memory; registers
// read zero until first written (valid bits), PC = 3072, HI/LO = 0.
// Depends on mse_pkg and mse_muldiv.
`default_nettype none
module mips32_subset_execute
  import mse_pkg::*;
#(
  parameter int DATA_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] instr,
  input  wire logic [31:0] in_value,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [31:0]      next_pc,
  output logic             in_used,
  output logic             out_valid,
  output logic [1:0]       out_format,
  output logic [31:0]      out_value,
  output logic             div_zero
);
  localparam int AW = $clog2(DATA_WORDS);

  state_t state, state_next;
  logic [31:0] gpr [32];
  logic [31:0] dmem [DATA_WORDS];
  logic [31:0] gv;                 // valid bit per register
  logic [31:0] ra_q, rb_q, rd_q, mem_q;
  logic [31:0] ins, inv, pc, hi, lo;
  logic [AW-1:0] clr;

  // Decode of the held instruction.
  logic [5:0] opc, fn;
  logic [4:0] rt, rd, sh;
  logic [31:0] imm, simm, a, b, addr, pc1;
  assign opc = ins[31:26]; assign fn = ins[5:0];
  assign rt = ins[20:16]; assign rd = ins[15:11];
  assign sh = ins[10:6];
  assign imm = {16'd0, ins[15:0]};
  assign simm = {{16{ins[15]}}, ins[15:0]};
  assign a = ra_q; assign b = rb_q;
  assign addr = a + simm;
  assign pc1 = pc + 32'd1;

  logic [AW-1:0] wi;
  assign wi = addr[AW+1:2];
  logic [4:0] bl;
  assign bl = {addr[1:0], 3'b000};
  logic [4:0] hl;
  assign hl = {addr[1], 4'b0000};

  // Execute results.
  logic        wr_en, mem_we, take, md_go, md_div, dz, iu, ov;
  logic [4:0]  wr_idx;
  logic [31:0] wr_val, mem_wd, npc, ovv;
  logic [1:0]  ofm;
  logic [31:0] tb, th, sa;
  assign tb = (mem_q >> bl) & 32'hFF;
  assign th = (mem_q >> hl) & 32'hFFFF;

  always_comb begin
    wr_en = 1'b0; wr_idx = rd; wr_val = '0; mem_we = 1'b0; mem_wd = mem_q;
    take = 1'b0; npc = pc1; md_go = 1'b0; md_div = 1'b0; dz = 1'b0;
    iu = 1'b0; ov = 1'b0; ofm = 2'd0; ovv = '0;
    sa = $unsigned($signed(b) >>> a[4:0]);
    case (opc)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL: begin wr_en = 1'b1; wr_val = b << sh; end
          FN_SRL: begin wr_en = 1'b1; wr_val = b >> sh; end
          FN_SRA: begin wr_en = 1'b1; wr_val = $unsigned($signed(b) >>> sh); end
          FN_SLLV: begin wr_en = 1'b1; wr_val = b << a[4:0]; end
          FN_SRLV: begin wr_en = 1'b1; wr_val = b >> a[4:0]; end
          FN_SRAV: begin wr_en = 1'b1; wr_val = sa; end
          FN_JR: npc = a;
          FN_JALR: begin npc = a; wr_en = 1'b1; wr_val = pc1; end
          FN_MFHI: begin wr_en = 1'b1; wr_val = hi; end
          FN_MFLO: begin wr_en = 1'b1; wr_val = lo; end
          FN_MULT, FN_MULTU: md_go = 1'b1;
          FN_DIV, FN_DIVU: begin
            md_div = 1'b1;
            if (b == 32'd0) dz = 1'b1; else md_go = 1'b1;
          end
          FN_ADD, FN_ADDU: begin wr_en = 1'b1; wr_val = a + b; end
          FN_SUB, FN_SUBU: begin wr_en = 1'b1; wr_val = a - b; end
          FN_AND: begin wr_en = 1'b1; wr_val = a & b; end
          FN_OR: begin wr_en = 1'b1; wr_val = a | b; end
          FN_XOR: begin wr_en = 1'b1; wr_val = a ^ b; end
          FN_NOR: begin wr_en = 1'b1; wr_val = ~(a | b); end
          FN_SLT: begin wr_en = 1'b1; wr_val = {31'd0, $signed(a) < $signed(b)}; end
          FN_SLTU: begin wr_en = 1'b1; wr_val = {31'd0, a < b}; end
          default: ;
        endcase
      end
      OP_REGIMM: begin
        if (rt == 5'd1) take = !a[31];
        else if (rt == 5'd0) take = a[31];
      end
      OP_J: npc = {pc1[31:26], ins[25:0]};
      OP_JAL: begin
        npc = {pc1[31:26], ins[25:0]}; wr_en = 1'b1; wr_idx = 5'd31; wr_val = pc1;
      end
      OP_BEQ: take = (a == b);
      OP_BNE: take = (a != b);
      OP_BLEZ: take = a[31] || (a == 32'd0);
      OP_BGTZ: take = !a[31] && (a != 32'd0);
      OP_ADDI, OP_ADDIU: begin wr_en = 1'b1; wr_idx = rt; wr_val = a + simm; end
      OP_SLTI: begin
        wr_en = 1'b1; wr_idx = rt; wr_val = {31'd0, $signed(a) < $signed(simm)};
      end
      OP_SLTIU: begin wr_en = 1'b1; wr_idx = rt; wr_val = {31'd0, a < simm}; end
      OP_ANDI: begin wr_en = 1'b1; wr_idx = rt; wr_val = a & imm; end
      OP_ORI: begin wr_en = 1'b1; wr_idx = rt; wr_val = a | imm; end
      OP_XORI: begin wr_en = 1'b1; wr_idx = rt; wr_val = a ^ imm; end
      OP_LUI: begin wr_en = 1'b1; wr_idx = rt; wr_val = {ins[15:0], 16'd0}; end
      OP_LB: begin wr_en = 1'b1; wr_idx = rt; wr_val = {{24{tb[7]}}, tb[7:0]}; end
      OP_LH: begin wr_en = 1'b1; wr_idx = rt; wr_val = {{16{th[15]}}, th[15:0]}; end
      OP_LW: begin wr_en = 1'b1; wr_idx = rt; wr_val = mem_q; end
      OP_LBU: begin wr_en = 1'b1; wr_idx = rt; wr_val = tb; end
      OP_LHU: begin wr_en = 1'b1; wr_idx = rt; wr_val = th; end
      OP_SB: begin
        mem_we = 1'b1;
        mem_wd = (mem_q & ~(32'hFF << bl)) | ((b & 32'hFF) << bl);
      end
      OP_SH: begin
        mem_we = 1'b1;
        mem_wd = (mem_q & ~(32'hFFFF << hl)) | ((b & 32'hFFFF) << hl);
      end
      OP_SW: begin mem_we = 1'b1; mem_wd = b; end
      OP_IN: begin
        if (sh == 5'd1 || sh == 5'd2) begin wr_en = 1'b1; wr_val = inv; iu = 1'b1; end
        else if (sh == 5'd3) begin wr_en = 1'b1; wr_val = inv & 32'hFF; iu = 1'b1; end
      end
      OP_OUT: begin
        ov = 1'b1;
        case (sh)
          5'd1: begin ofm = 2'd0; ovv = rd_q; end
          5'd2: begin ofm = 2'd1; ovv = rd_q; end
          5'd3: begin ofm = 2'd2; ovv = rd_q & 32'hFF; end
          5'd4: begin ofm = 2'd3; ovv = rd_q; end
          default: ov = 1'b0;
        endcase
      end
      default: ;
    endcase
    if (take) npc = pc1 + simm;
  end

  // Multiply/divide unit.
  md_req_t md_req;
  logic md_busy;
  logic [31:0] md_hi, md_lo;
  assign md_req.start = (state == ST_EXEC) && md_go;
  assign md_req.is_signed = (fn == FN_MULT) || (fn == FN_DIV);
  assign md_req.a = a;
  assign md_req.b = b;
  mse_muldiv u_md (
    .clk(clk), .rst(rst), .req(md_req), .is_div(md_div),
    .busy(md_busy), .hi(md_hi), .lo(md_lo)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == AW'(DATA_WORDS - 1)) state_next = ST_IDLE;
      ST_IDLE: if (in_valid) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = md_go ? ST_MUL : ST_OUT;
      ST_MUL: state_next = ST_DIV;
      ST_DIV: if (!md_busy) state_next = ST_WB;
      ST_WB: state_next = ST_OUT;
      ST_OUT: if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = (state == ST_IDLE);
    res_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR; clr <= '0; gv <= '0; pc <= 32'd3072; hi <= '0; lo <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + AW'(1);
      if (cfg_we) pc <= cfg_wdata;
      if (state == ST_EXEC) begin
        pc <= npc;
        if (wr_en && wr_idx != 5'd0) gv[wr_idx] <= 1'b1;
      end
      if (state == ST_WB) begin hi <= md_hi; lo <= md_lo; end
    end
  end

  // Register file RAM: three read ports by replication, one write.
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && wr_en) gpr[wr_idx] <= wr_val;
    if (state == ST_IDLE) begin
      ra_q <= (instr[25:21] != 5'd0 && gv[instr[25:21]]) ? gpr[instr[25:21]] : 32'd0;
      rb_q <= (instr[20:16] != 5'd0 && gv[instr[20:16]]) ? gpr[instr[20:16]] : 32'd0;
      rd_q <= (instr[15:11] != 5'd0 && gv[instr[15:11]]) ? gpr[instr[15:11]] : 32'd0;
      ins <= instr; inv <= in_value;
    end
  end

  // Data memory: zeroed in CLEAR, read in READ, modify and write in EXEC.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) dmem[clr] <= '0;
    else if (state == ST_EXEC && mem_we) dmem[wi] <= mem_wd;
    mem_q <= dmem[wi];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      next_pc <= npc; in_used <= iu; out_valid <= ov; out_format <= ofm;
      out_value <= ovv; div_zero <= dz;
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_mips32_subset_execute.sv =====
// Self-checking testbench for mips32_subset_execute: drives instruction transactions,
// predicts next PC, in_used, console output and divide-by-zero from its CPU state model.
// Depends on mse_pkg and the RTL of the block.
`default_nettype none
module tb_mips32_subset_execute;
  import mse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_WORDS = 4096;
  localparam int LIMIT_CYCLES = 4000000;

  typedef struct packed {
    logic [31:0] npc;
    logic        used;
    logic        ovalid;
    logic [1:0]  ofmt;
    logic [31:0] oval;
    logic        dz;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] instr = '0;
  logic [31:0] in_value = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [31:0] next_pc;
  logic in_used, out_valid, div_zero;
  logic [1:0] out_format;
  logic [31:0] out_value;

  // Model state of the CPU.
  logic [31:0] m_gpr [32];
  logic [31:0] m_hi, m_lo, m_pc;
  logic [31:0] m_mem [MEM_WORDS];
  exec_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  mips32_subset_execute dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .instr, .in_value,
    .res_valid, .res_ready, .next_pc, .in_used, .out_valid, .out_format, .out_value,
    .div_zero
  );

  // Watchdog: reset plus the memory clearing pass plus the slowest run, many times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_mips32_subset_execute failed");
      $finish;
    end
  end

  // Receiver: stall at random, set by the current idling phase.
  always @(posedge clk) begin
    if (rst) res_ready <= 1'b0;
    else res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, results_seen);
  endtask

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    exec_result_t e;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", next_pc, '0);
      end else begin
        e = pending_results.pop_front();
        if (next_pc !== e.npc) report_mismatch("next_pc", next_pc, e.npc);
        if (in_used !== e.used)
          report_mismatch("in_used", {31'd0, in_used}, {31'd0, e.used});
        if (out_valid !== e.ovalid)
          report_mismatch("out_valid", {31'd0, out_valid}, {31'd0, e.ovalid});
        if (out_format !== e.ofmt)
          report_mismatch("out_format", {30'd0, out_format}, {30'd0, e.ofmt});
        if (out_value !== e.oval) report_mismatch("out_value", out_value, e.oval);
        if (div_zero !== e.dz)
          report_mismatch("div_zero", {31'd0, div_zero}, {31'd0, e.dz});
      end
      results_seen++;
    end
  end

  function automatic logic [31:0] reg_rd(input logic [4:0] i);
    return (i == 0) ? 32'd0 : m_gpr[i];
  endfunction

  function automatic void reg_wr(input logic [4:0] i, input logic [31:0] v);
    if (i != 0) m_gpr[i] = v;
  endfunction

  // Execute one instruction on the model state and return the expected result.
  function automatic exec_result_t execute_instr(input logic [31:0] ins, input logic [31:0] inv);
    exec_result_t r;
    logic [5:0] opc, fn;
    logic [4:0] rs, rt, rd, sh;
    logic [31:0] imm, simm, a, b, pc1, npc, addr, w, v;
    logic [63:0] p;
    int unsigned wi;
    int bl, hl;
    logic take;
    opc = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
    sh = ins[10:6]; fn = ins[5:0];
    imm = {16'd0, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    a = reg_rd(rs); b = reg_rd(rt);
    pc1 = m_pc + 32'd1; npc = pc1;
    r = '0;
    addr = a + simm;
    wi = (addr >> 2) % MEM_WORDS;
    bl = addr[1:0] * 8;
    hl = addr[1] * 16;
    w = m_mem[wi];
    take = 1'b0;
    case (opc)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL: reg_wr(rd, b << sh);
          FN_SRL: reg_wr(rd, b >> sh);
          FN_SRA: reg_wr(rd, $signed(b) >>> sh);
          FN_SLLV: reg_wr(rd, b << a[4:0]);
          FN_SRLV: reg_wr(rd, b >> a[4:0]);
          FN_SRAV: reg_wr(rd, $signed(b) >>> a[4:0]);
          FN_JR: npc = a;
          FN_JALR: begin npc = a; reg_wr(rd, pc1); end
          FN_MFHI: reg_wr(rd, m_hi);
          FN_MFLO: reg_wr(rd, m_lo);
          FN_MULT: begin
            p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            {m_hi, m_lo} = p;
          end
          FN_MULTU: begin
            p = {32'd0, a} * {32'd0, b};
            {m_hi, m_lo} = p;
          end
          FN_DIV: begin
            if (b == 0) r.dz = 1'b1;
            else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
              m_lo = 32'h8000_0000; m_hi = 32'd0;
            end else begin
              m_lo = $signed(a) / $signed(b);
              m_hi = $signed(a) % $signed(b);
            end
          end
          FN_DIVU: begin
            if (b == 0) r.dz = 1'b1;
            else begin m_lo = a / b; m_hi = a % b; end
          end
          FN_ADD, FN_ADDU: reg_wr(rd, a + b);
          FN_SUB, FN_SUBU: reg_wr(rd, a - b);
          FN_AND: reg_wr(rd, a & b);
          FN_OR: reg_wr(rd, a | b);
          FN_XOR: reg_wr(rd, a ^ b);
          FN_NOR: reg_wr(rd, ~(a | b));
          FN_SLT: reg_wr(rd, {31'd0, $signed(a) < $signed(b)});
          FN_SLTU: reg_wr(rd, {31'd0, a < b});
          default: ;
        endcase
      end
      OP_REGIMM: begin
        if (rt == 5'd1) take = ~a[31];
        else if (rt == 5'd0) take = a[31];
      end
      OP_J: npc = {pc1[31:26], ins[25:0]};
      OP_JAL: begin reg_wr(5'd31, pc1); npc = {pc1[31:26], ins[25:0]}; end
      OP_BEQ: take = (a == b);
      OP_BNE: take = (a != b);
      OP_BLEZ: take = ($signed(a) <= 0);
      OP_BGTZ: take = ($signed(a) > 0);
      OP_ADDI, OP_ADDIU: reg_wr(rt, a + simm);
      OP_SLTI: reg_wr(rt, {31'd0, $signed(a) < $signed(simm)});
      OP_SLTIU: reg_wr(rt, {31'd0, a < simm});
      OP_ANDI: reg_wr(rt, a & imm);
      OP_ORI: reg_wr(rt, a | imm);
      OP_XORI: reg_wr(rt, a ^ imm);
      OP_LUI: reg_wr(rt, imm << 16);
      OP_LB: begin v = (w >> bl) & 32'hFF; reg_wr(rt, {{24{v[7]}}, v[7:0]}); end
      OP_LH: begin v = w >> hl; reg_wr(rt, {{16{v[15]}}, v[15:0]}); end
      OP_LW: reg_wr(rt, w);
      OP_LBU: reg_wr(rt, (w >> bl) & 32'hFF);
      OP_LHU: reg_wr(rt, (w >> hl) & 32'hFFFF);
      OP_SB: m_mem[wi] = (w & ~(32'hFF << bl)) | ((b & 32'hFF) << bl);
      OP_SH: m_mem[wi] = (w & ~(32'hFFFF << hl)) | ((b & 32'hFFFF) << hl);
      OP_SW: m_mem[wi] = b;
      OP_IN: begin
        if (sh == 5'd1 || sh == 5'd2) begin reg_wr(rd, inv); r.used = 1'b1; end
        else if (sh == 5'd3) begin reg_wr(rd, inv & 32'hFF); r.used = 1'b1; end
      end
      OP_OUT: begin
        v = reg_rd(rd);
        case (sh)
          5'd1: begin r.ovalid = 1'b1; r.ofmt = 2'd0; r.oval = v; end
          5'd2: begin r.ovalid = 1'b1; r.ofmt = 2'd1; r.oval = v; end
          5'd3: begin r.ovalid = 1'b1; r.ofmt = 2'd2; r.oval = v & 32'hFF; end
          5'd4: begin r.ovalid = 1'b1; r.ofmt = 2'd3; r.oval = v; end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (take) npc = pc1 + simm;
    m_pc = npc;
    r.npc = npc;
    return r;
  endfunction

  // Send one instruction transaction; predict it at acceptance. Valid stays high
  // after acceptance until the next idle cycle or drain drops it.
  task automatic send_instr(input logic [31:0] ins, input logic [31:0] inv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    instr <= ins;
    in_value <= inv;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(execute_instr(ins, inv));
  endtask

  // Drop valid, wait for all results, then let a multiply or divide worth of cycles pass.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Write start_pc while idle; the model reloads its PC too.
  task automatic write_start_pc(input logic [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_pc = v;
  endtask

  function automatic logic [31:0] r_type(input logic [4:0] rs, rt, rd, sh, input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_type(input logic [5:0] op, input logic [4:0] rs, rt,
                                         input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Offsets stay in a narrow window most of the time so loads hit stored words.
  function automatic logic [31:0] rand_instr();
    logic [5:0] ops [26] = '{OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ,
      OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW, OP_IN, OP_OUT};
    logic [5:0] fns [24] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
      FN_JALR, FN_MFHI, FN_MFLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU,
      FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    logic [31:0] w;
    int k;
    k = $urandom_range(99);
    w = $urandom();
    if (k < 5) return w;
    if (k < 40) begin
      w[31:26] = OP_SPECIAL;
      w[5:0] = fns[$urandom_range(23)];
    end else begin
      w[31:26] = ops[$urandom_range(25)];
      if (w[31:26] >= OP_LB && w[31:26] <= OP_SW && $urandom_range(3) != 0)
        w[15:0] = 16'($urandom_range(63));
      if (w[31:26] == OP_IN || w[31:26] == OP_OUT) w[10:6] = 5'($urandom_range(5));
      if (w[31:26] == OP_REGIMM) w[20:16] = 5'($urandom_range(2));
    end
    if ($urandom_range(3) == 0) w[25:21] = 5'd0;
    return w;
  endfunction

  task automatic test_directed_ops;
    send_instr(i_type(OP_IN, 5'd0, 5'd0, {5'd1, 5'd1, 6'd0}), 32'hFFFF_FFFF);
    send_instr(i_type(OP_IN, 5'd0, 5'd0, {5'd2, 5'd2, 6'd0}), 32'h8000_0000);
    send_instr(i_type(OP_IN, 5'd0, 5'd0, {5'd3, 5'd3, 6'd0}), 32'h1234_56C8);
    send_instr(i_type(OP_IN, 5'd0, 5'd0, {5'd4, 5'd7, 6'd0}), 32'hDEAD_BEEF);
    send_instr(i_type(OP_IN, 5'd0, 5'd0, {5'd0, 5'd1, 6'd0}), 32'd5); // write to r0 drops
    send_instr(i_type(OP_OUT, 5'd0, 5'd0, {5'd3, 5'd3, 6'd0}), 32'd0);
    send_instr(i_type(OP_OUT, 5'd0, 5'd0, {5'd1, 5'd5, 6'd0}), 32'd0);
    send_instr(r_type(5'd2, 5'd1, 5'd4, 5'd0, FN_DIV), 32'd0);   // min / -1 overflow
    send_instr(r_type(5'd1, 5'd0, 5'd4, 5'd0, FN_DIVU), 32'd0);  // divide by zero
    send_instr(r_type(5'd1, 5'd2, 5'd4, 5'd0, FN_MULT), 32'd0);
    send_instr(r_type(5'd0, 5'd0, 5'd5, 5'd0, FN_MFHI), 32'd0);
    send_instr(r_type(5'd1, 5'd2, 5'd6, 5'd0, FN_NOR), 32'd0);
    send_instr(r_type(5'd0, 5'd2, 5'd7, 5'd31, FN_SRA), 32'd0);
    send_instr(i_type(OP_SW, 5'd0, 5'd1, 16'hFFFC), 32'd0);      // wraps to last word
    send_instr(i_type(OP_SB, 5'd0, 5'd3, 16'h0001), 32'd0);
    send_instr(i_type(OP_LB, 5'd0, 5'd8, 16'h0001), 32'd0);
    send_instr(i_type(OP_LHU, 5'd0, 5'd9, 16'hFFFE), 32'd0);
    send_instr(i_type(OP_ORI, 5'd0, 5'd10, 16'h8001), 32'd0);
    send_instr(i_type(OP_REGIMM, 5'd1, 5'd1, 16'h0004), 32'd0);  // BGEZ on negative
    send_instr(i_type(OP_REGIMM, 5'd1, 5'd0, 16'hFFFE), 32'd0);  // BLTZ taken back
    send_instr(i_type(OP_REGIMM, 5'd1, 5'd7, 16'h0010), 32'd0);  // other rt: nothing
    send_instr({OP_JAL, 26'h3FF_FFFF}, 32'd0);
    send_instr(r_type(5'd31, 5'd0, 5'd11, 5'd0, FN_JALR), 32'd0);
    send_instr(32'hFC00_0000, 32'd0);                            // unknown opcode
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_instr(rand_instr(), $urandom());
  endtask

  task automatic test_start_pc_settings;
    write_start_pc(32'hFFFF_FFFF);
    test_random_phase(40, 0, 0);
    write_start_pc(32'd0);
    test_random_phase(40, 27, 27);
    write_start_pc($urandom());
    test_random_phase(40, 0, 62);
  endtask

  initial begin
    foreach (m_gpr[i]) m_gpr[i] = '0;
    foreach (m_mem[i]) m_mem[i] = '0;
    m_hi = '0; m_lo = '0; m_pc = 32'd3072;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_random_phase(420, 0, 0);
    test_random_phase(420, 62, 0);
    test_random_phase(420, 0, 62);
    test_random_phase(420, 27, 27);
    test_start_pc_settings();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    $display("Ran %0d instruction transactions over four idling phases and four start_pc",
             results_seen);
    $display("settings, with %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("tb_mips32_subset_execute passed");
    end else begin
      $display("tb_mips32_subset_execute failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
